@@ hdl/pnguf_pkg.sv @@
package pnguf_pkg;

   localparam int BYTE_W    = 8;
   localparam int MAX_LANES = 4;
   localparam int PIXEL_W   = BYTE_W * MAX_LANES;
   localparam int FT_W      = 3;
   localparam int BPP_W     = 3;

   // filter type codes carried on the request tuser
   localparam logic [FT_W-1:0] FT_NONE  = 3'd0;
   localparam logic [FT_W-1:0] FT_SUB   = 3'd1;
   localparam logic [FT_W-1:0] FT_UP    = 3'd2;
   localparam logic [FT_W-1:0] FT_AVG   = 3'd3;
   localparam logic [FT_W-1:0] FT_PAETH = 3'd4;

   localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

   // one reconstructed pixel on its way to the response side
   typedef struct packed {
      logic               last;
      logic [PIXEL_W-1:0] data;
   } beat_type;

endpackage

@@ hdl/pnguf_lane.sv @@
module pnguf_lane
   import pnguf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              active,
   input  logic              row_start,
   input  logic [FT_W-1:0]   filter_type,
   input  logic [BYTE_W-1:0] raw_byte,
   input  logic [BYTE_W-1:0] above_byte,
   output logic [BYTE_W-1:0] pixel_byte
);

   logic [BYTE_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0] upleft_ff, upleft_in;

   logic [BYTE_W-1:0] pred_a;
   logic [BYTE_W-1:0] pred_c;
   logic [BYTE_W:0]   sum_ab;
   logic [BYTE_W:0]   twice_c;
   logic [BYTE_W-1:0] dist_a;
   logic [BYTE_W-1:0] dist_b;
   logic [BYTE_W:0]   dist_c;
   logic [BYTE_W-1:0] paeth;
   logic [BYTE_W-1:0] pred;
   logic [BYTE_W-1:0] recon;

   // left and upper-left read as zero on the first pixel of a row
   assign pred_a = row_start ? '0 : left_ff;
   assign pred_c = row_start ? '0 : upleft_ff;

   // Paeth distances: |b-c|, |a-c|, |a+b-2c|
   assign sum_ab  = {1'b0, pred_a} + {1'b0, above_byte};
   assign twice_c = {pred_c, 1'b0};
   assign dist_a  = (above_byte > pred_c) ? above_byte - pred_c : pred_c - above_byte;
   assign dist_b  = (pred_a > pred_c) ? pred_a - pred_c : pred_c - pred_a;
   assign dist_c  = (sum_ab > twice_c) ? sum_ab - twice_c : twice_c - sum_ab;

   // ties favor left, then above
   always_comb begin
      priority if (({1'b0, dist_a} <= {1'b0, dist_b}) && ({1'b0, dist_a} <= dist_c)) begin
         paeth = pred_a;
      end else if ({1'b0, dist_b} <= dist_c) begin
         paeth = above_byte;
      end else begin
         paeth = pred_c;
      end
   end

   // select the predictor; unknown codes pass raw bytes through
   always_comb begin
      unique case (filter_type)
         FT_SUB:   pred = pred_a;
         FT_UP:    pred = above_byte;
         FT_AVG:   pred = sum_ab[BYTE_W:1];
         FT_PAETH: pred = paeth;
         default:  pred = '0;
      endcase
   end

   assign recon      = raw_byte + pred;
   assign pixel_byte = active ? recon : '0;

   // keep this pixel as the next one's left and upper-left
   always_comb begin
      left_in   = left_ff;
      upleft_in = upleft_ff;
      if (advance) begin
         left_in   = active ? recon : '0;
         upleft_in = active ? above_byte : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         upleft_ff <= '0;
      end else begin
         left_ff   <= left_in;
         upleft_ff <= upleft_in;
      end
   end

endmodule

@@ hdl/pnguf_merge.sv @@
module pnguf_merge
   import pnguf_pkg::*;
#(
   parameter int LANES = 4
)
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [LANES-1:0][BYTE_W-1:0] lane_bytes,
   input  logic                         in_last,
   output logic                         out_valid,
   input  logic                         out_ready,
   output beat_type                     out_beat
);

   beat_type merged;
   beat_type main_ff, main_in;
   beat_type skid_ff, skid_in;
   logic     main_valid_ff, main_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   logic     accept;
   logic     pop;

   // gather lane bytes into one pixel word, absent lanes read zero
   genvar gi;
   generate
      for (gi = 0; gi < MAX_LANES; gi++) begin : g_pack
         if (gi < LANES) begin : g_lane
            assign merged.data[gi*BYTE_W +: BYTE_W] = lane_bytes[gi];
         end else begin : g_zero
            assign merged.data[gi*BYTE_W +: BYTE_W] = '0;
         end
      end
   endgenerate
   assign merged.last = in_last;

   assign in_ready  = !skid_valid_ff;
   assign accept    = in_valid && in_ready;
   assign out_valid = main_valid_ff;
   assign out_beat  = main_ff;
   assign pop       = main_valid_ff && out_ready;

   // advance the output register, park a beat in the skid stage on stall
   always_comb begin
      main_in       = main_ff;
      skid_in       = skid_ff;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            main_in = merged;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (main_valid_ff) begin
            skid_in       = merged;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = merged;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid stage holds a beat while output register is empty");

   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(accept && main_valid_ff && !out_ready))
      else $error("skid stage filled without a stalled output");

   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (main_valid_ff && !skid_valid_ff))
      else $error("skid beat not moved to output register");

endmodule

@@ hdl/png_row_unfilter_top.sv @@
// Channel  | Handshake              | Payload
// ---------+------------------------+-----------------------------------------
// request  | req_tvalid/req_tready  | tdata raw 0..3, above 0..3; tuser filter;
//          |                        | tlast end of row
// response | rsp_tvalid/rsp_tready  | tdata pixel 0..3; tlast end of row
// config   | csr_valid/csr_ready    | csr_data bytes per pixel
//
// One pixel per cycle while the response is not stalled; each taken beat is
// registered in the output stage. The lanes reconstruct all bytes of a pixel
// in the cycle it is taken. A two-entry output stage (register plus skid) keeps
// req_tready registered; it drops only after two beats are held under a stalled response.
// Reset sets bytes per pixel to 4 and marks the next pixel as a row start.
module png_row_unfilter_top
   import pnguf_pkg::*;
#(
   parameter int LANES = 4
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [2*PIXEL_W-1:0]  req_tdata,  // raw_byte_0..3, above_byte_0..3
   input  logic [FT_W-1:0]       req_tuser,  // filter_type
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,  // pixel_byte_0..3
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [BPP_W-1:0]      csr_data
);

   logic [BPP_W-1:0]             bpp_ff, bpp_in;
   logic                         row_start_ff, row_start_in;
   logic                         accept;
   logic                         wide_active;
   logic [LANES-1:0][BYTE_W-1:0] lane_bytes;
   beat_type                     out_beat;

   assign csr_ready   = 1'b1;
   assign accept      = req_tvalid && req_tready;
   // the fourth lane runs only for pixels of four or more bytes
   assign wide_active = (LANES >= MAX_LANES) && bpp_ff[BPP_W-1];

   // hold the config and the row-start flag
   always_comb begin
      bpp_in       = bpp_ff;
      row_start_in = row_start_ff;
      if (csr_valid && csr_ready) begin
         bpp_in = csr_data;
      end
      if (accept) begin
         row_start_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff       <= BPP_RESET;
         row_start_ff <= 1'b1;
      end else begin
         bpp_ff       <= bpp_in;
         row_start_ff <= row_start_in;
      end
   end

   // one reconstruction lane per pixel byte
   genvar gi;
   generate
      for (gi = 0; gi < LANES; gi++) begin : g_lane
         localparam bit ALWAYS_ON = (gi < MAX_LANES - 1);
         pnguf_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .advance     (accept),
            .active      (ALWAYS_ON || wide_active),
            .row_start   (row_start_ff),
            .filter_type (req_tuser),
            .raw_byte    (req_tdata[gi*BYTE_W +: BYTE_W]),
            .above_byte  (req_tdata[PIXEL_W + gi*BYTE_W +: BYTE_W]),
            .pixel_byte  (lane_bytes[gi])
         );
      end
   endgenerate

   pnguf_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .lane_bytes (lane_bytes),
      .in_last    (req_tlast),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_beat   (out_beat)
   );

   assign rsp_tdata = out_beat.data;
   assign rsp_tlast = out_beat.last;

   a_row_start_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (row_start_ff == $past(req_tlast)))
      else $error("row-start flag does not follow end of row");

   a_idle_keeps_row: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(row_start_ff))
      else $error("row-start flag moved without a beat");

   a_narrow_lane_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(wide_active) && $rose(rsp_tvalid))
         |-> (rsp_tdata[PIXEL_W-1 -: BYTE_W] == '0))
      else $error("inactive fourth lane produced a nonzero byte");

endmodule

@@ tb/sv/png_row_unfilter_top_test.sv @@
module png_row_unfilter_top_test
   import pnguf_pkg::*;
();

   localparam int LANES_TB = 4;
   localparam logic [FT_W-1:0] FT_SPARE_LO = FT_W'(FT_PAETH + 1);
   localparam logic [FT_W-1:0] FT_SPARE_HI = '1;
   localparam int ROW_MAX = 32;

   // Keep the row state and the reconstructed pixels still owed by the block.
   class pixel_scoreboard;
      bit [BPP_W-1:0] bytes_per_pixel;
      bit [BYTE_W-1:0] left_byte[MAX_LANES];
      bit [BYTE_W-1:0] upper_left_byte[MAX_LANES];
      bit row_start;
      beat_type pixels_owed[$];
      int failures;

      function new();
         bytes_per_pixel = BPP_RESET;
         foreach (left_byte[i]) begin
            left_byte[i] = '0;
            upper_left_byte[i] = '0;
         end
         row_start = 1'b1;
         failures = 0;
      endfunction

      function void set_bytes_per_pixel(bit [BPP_W-1:0] value);
         bytes_per_pixel = value;
      endfunction

      // Pick the neighbor closest to a + b - c; ties go left, then above.
      function bit [BYTE_W-1:0] paeth_choice(bit [BYTE_W-1:0] a, bit [BYTE_W-1:0] b,
                                             bit [BYTE_W-1:0] c);
         int pa, pb, pc;
         pa = (b > c) ? b - c : c - b;
         pb = (a > c) ? a - c : c - a;
         pc = (int'(a) + int'(b) > 2 * int'(c)) ? int'(a) + int'(b) - 2 * int'(c)
                                                : 2 * int'(c) - int'(a) - int'(b);
         if (pa <= pb && pa <= pc)
            return a;
         if (pb <= pc)
            return b;
         return c;
      endfunction

      // Reconstruct one accepted pixel, advance the row state, queue the beat.
      function bit [PIXEL_W-1:0] note_pixel(logic [FT_W-1:0] filter, bit [PIXEL_W-1:0] raw,
                                            bit [PIXEL_W-1:0] above, bit row_end);
         int lanes;
         bit [BYTE_W-1:0] a, b, c, pred;
         bit [PIXEL_W-1:0] pixel;
         beat_type owed;
         lanes = (bytes_per_pixel >= 4) ? 4 : 3;
         if (lanes > LANES_TB)
            lanes = LANES_TB;
         pixel = '0;
         for (int i = 0; i < MAX_LANES; i++) begin
            b = above[BYTE_W*i +: BYTE_W];
            a = row_start ? '0 : left_byte[i];
            c = row_start ? '0 : upper_left_byte[i];
            if (i >= lanes) begin
               left_byte[i] = '0;
               upper_left_byte[i] = '0;
            end else begin
               case (filter)
                  FT_SUB:   pred = a;
                  FT_UP:    pred = b;
                  FT_AVG:   pred = BYTE_W'((int'(a) + int'(b)) >> 1);
                  FT_PAETH: pred = paeth_choice(a, b, c);
                  default:  pred = '0;
               endcase
               pixel[BYTE_W*i +: BYTE_W] = raw[BYTE_W*i +: BYTE_W] + pred;
               left_byte[i] = pixel[BYTE_W*i +: BYTE_W];
               upper_left_byte[i] = b;
            end
         end
         row_start = row_end;
         owed.last = row_end;
         owed.data = pixel;
         pixels_owed.push_back(owed);
         return pixel;
      endfunction

      // Compare one response beat with the oldest owed pixel.
      function void check_pixel(logic [PIXEL_W-1:0] data, logic last);
         beat_type owed;
         if (pixels_owed.size() == 0) begin
            $error("response beat with nothing owed: data %h last %0d", data, last);
            failures++;
            return;
         end
         owed = pixels_owed.pop_front();
         for (int i = 0; i < MAX_LANES; i++) begin
            if (data[BYTE_W*i +: BYTE_W] !== owed.data[BYTE_W*i +: BYTE_W]) begin
               $error("pixel_byte_%0d: expected %0d, actual %0d", i,
                      owed.data[BYTE_W*i +: BYTE_W], data[BYTE_W*i +: BYTE_W]);
               failures++;
            end
         end
         if (last !== owed.last) begin
            $error("row_done: expected %0d, actual %0d", owed.last, last);
            failures++;
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [2*PIXEL_W-1:0] req_tdata;
   logic [FT_W-1:0]      req_tuser;
   logic                 req_tlast;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [PIXEL_W-1:0]   rsp_tdata;
   logic                 rsp_tlast;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [BPP_W-1:0]     csr_data;

   pixel_scoreboard board;
   int pixels_sent;
   int burst_left;
   int rsp_hold_cycles;
   bit [PIXEL_W-1:0] last_row[ROW_MAX];
   bit [PIXEL_W-1:0] this_row[ROW_MAX];
   int prev_len;

   png_row_unfilter_top #(.LANES(LANES_TB)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("status: fail");
      $finish;
   end

   // Check every response beat taken at a rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_pixel(rsp_tdata, rsp_tlast);
   end

   // Stall the response side on one of four patterns, picked anew at random as
   // the phase count advances; a requested hold-off is counted down here.
   initial begin
      int mode;
      int phase;
      mode = 0;
      phase = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0)
            mode = $urandom_range(0, 3);
         phase++;
         if (rsp_hold_cycles > 0) begin
            rsp_tready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            case (mode)
               0:       rsp_tready = 1'b1;
               1:       rsp_tready = 1'($urandom_range(0, 1));
               2:       rsp_tready = (phase % 4 != 0);
               default: rsp_tready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic bit [BYTE_W-1:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return BYTE_W'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [FT_W-1:0] pick_filter();
      if ($urandom_range(0, 19) == 0)
         return FT_W'($urandom_range(FT_SPARE_LO, FT_SPARE_HI));
      return FT_W'($urandom_range(FT_NONE, FT_PAETH));
   endfunction

   function automatic bit [PIXEL_W-1:0] pick_pixel();
      return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
   endfunction

   // Drop valid and put junk on the payload.
   task automatic idle_cycle();
      @(negedge clock);
      req_tvalid = 1'b0;
      req_tdata = {$urandom, $urandom};
      req_tuser = FT_W'($urandom);
      req_tlast = 1'($urandom);
   endtask

   // Offer one pixel and hold it until the block takes the beat.
   task automatic send_pixel(logic [FT_W-1:0] filter, bit [PIXEL_W-1:0] raw,
                             bit [PIXEL_W-1:0] above, bit row_end,
                             output bit [PIXEL_W-1:0] pixel);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {above, raw};
      req_tuser = filter;
      req_tlast = row_end;
      do @(posedge clock); while (!req_tready);
      pixel = board.note_pixel(filter, raw, above, row_end);
      pixels_sent++;
   endtask

   task automatic send_directed(logic [FT_W-1:0] filter, bit [PIXEL_W-1:0] raw,
                                bit [PIXEL_W-1:0] above, bit row_end);
      bit [PIXEL_W-1:0] pixel;
      send_pixel(filter, raw, above, row_end, pixel);
   endtask

   // Burst the sender: random burst length, random gap between bursts.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) idle_cycle();
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
   endtask

   // Hold the input until every owed pixel is back, then let the block settle.
   task automatic drain();
      idle_cycle();
      while (board.pixels_owed.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bytes_per_pixel(bit [BPP_W-1:0] value);
      drain();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      board.set_bytes_per_pixel(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Send one scanline; above bytes come from the last row, zeros or noise.
   task automatic run_row(int len, bit steady);
      logic [FT_W-1:0] filter;
      bit mixed;
      int source;
      bit [PIXEL_W-1:0] above;
      filter = pick_filter();
      mixed = ($urandom_range(0, 9) == 0);
      source = $urandom_range(0, 3);
      for (int p = 0; p < len; p++) begin
         if (mixed)
            filter = pick_filter();
         case (source)
            0:       above = '0;
            1, 2:    above = (p < prev_len) ? last_row[p] : pick_pixel();
            default: above = pick_pixel();
         endcase
         if (!steady)
            pace_sender();
         send_pixel(filter, pick_pixel(), above, p == len - 1, this_row[p]);
      end
      last_row = this_row;
      prev_len = len;
   endtask

   initial begin
      bit [BPP_W-1:0] settings[10] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5,
                                       3'd4, 3'd3};
      int phase_end;
      int len;
      board = new();
      pixels_sent = 0;
      burst_left = 0;
      rsp_hold_cycles = 0;
      prev_len = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = FT_NONE;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      write_bytes_per_pixel(BPP_RESET);

      // first row of an image: byte extremes on raw and above, every filter
      send_directed(FT_NONE,  32'h7f80_ff00, 32'h0000_0000, 1'b0);
      send_directed(FT_SUB,   32'hffff_ffff, 32'h0000_0000, 1'b0);
      send_directed(FT_UP,    32'h0101_0101, 32'hffff_ffff, 1'b0);
      send_directed(FT_AVG,   32'h0000_0000, 32'hffff_ffff, 1'b0);
      send_directed(FT_PAETH, 32'h0102_0304, 32'h80ff_0001, 1'b1);
      // row start with Paeth: left and upper-left are zero
      send_directed(FT_PAETH, 32'h1122_3344, 32'h0000_ff40, 1'b0);
      // set left = upper-left, then Paeth ties on all three and on left/above
      send_directed(FT_NONE,  32'h3232_320a, 32'h3232_320a, 1'b0);
      send_directed(FT_PAETH, 32'h0000_0000, 32'h3232_321e, 1'b0);
      send_directed(FT_PAETH, 32'hff00_ff01, 32'h0000_0000, 1'b0);
      send_directed(FT_PAETH, 32'h00ff_0080, 32'hff00_80ff, 1'b0);
      // filter type changing within the row, then spare codes pass through
      send_directed(FT_AVG,   32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_directed(FT_SUB,   32'h0101_0101, 32'h0000_0000, 1'b0);
      send_directed(FT_SPARE_LO, 32'hdead_beef, 32'h1234_5678, 1'b0);
      send_directed(FT_W'(FT_SPARE_LO + 1), 32'h0000_0000, 32'hffff_ffff, 1'b0);
      send_directed(FT_SPARE_HI, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      // single-pixel rows
      send_directed(FT_SUB,   32'h0504_0302, 32'hffff_ffff, 1'b1);
      send_directed(FT_AVG,   32'h0000_0000, 32'hffff_ffff, 1'b1);
      send_directed(FT_UP,    32'hffff_ffff, 32'h0101_0101, 1'b1);
      // three-byte pixels: lane 3 ignored and cleared
      write_bytes_per_pixel(3'd3);
      send_directed(FT_NONE,  32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_directed(FT_SUB,   32'hff01_0101, 32'hffff_ffff, 1'b0);
      send_directed(FT_PAETH, 32'h8080_8080, 32'h7f7f_7f7f, 1'b1);

      // random rows under each register setting, extremes and out of range
      foreach (settings[s]) begin
         write_bytes_per_pixel(settings[s]);
         phase_end = pixels_sent + 45;
         if (s == 2) begin
            // long receiver hold-off while the sender keeps pushing
            rsp_hold_cycles = 60;
            run_row(24, 1'b1);
         end
         while (pixels_sent < phase_end) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, ROW_MAX)
                                              : $urandom_range(1, 8);
            run_row(len, s == 4);
            if (s == 5 && pixels_sent < phase_end && $urandom_range(0, 3) == 0)
               drain();
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (board.failures == 0 && board.pixels_owed.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
